/* design/sbda_pkg.sv */
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants
// Types, character codes and the divide-by-ten constants used by the signed
// binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

    // Field widths fixed by the channel definitions.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    // ASCII codes that the converter emits.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    // Division by ten as multiplication by ceil(2^35 / 10), exact for 32 bits.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // Phases of the conversion engine.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SPLIT,
        PH_SIGN,
        PH_DIGITS
    } phase_t;

    // One classified number waiting in the queue.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } job_t;

    // Handshake between the front and the back.
    typedef struct packed {
        logic valid;
        job_t job;
    } job_req_t;

endpackage

/* design/sbda_if.sv */
// ----------------------------------------------------------------------------
// sbda_in_if / sbda_out_if: valid-ready channels
// Input channel carries one signed integer, output channel one character.
// ----------------------------------------------------------------------------
interface sbda_in_if;
    import sbda_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
    import sbda_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* design/sbda_front.sv */
// ----------------------------------------------------------------------------
// sbda_front: input stage and job queue
// Accepts integers, splits off sign and magnitude, and holds them in a
// two-entry queue until the conversion engine takes them.
// ----------------------------------------------------------------------------
module sbda_front (
    input  logic              clk,
    input  logic              rst_n,
    sbda_in_if.sink           in_ch,
    output sbda_pkg::job_req_t req,
    input  logic              take
);
    import sbda_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    job_t       incoming;

    // Classify the incoming value: sign bit and unsigned magnitude.
    always_comb
    begin
        incoming.neg = in_ch.value[VALUE_W-1];
        incoming.mag = incoming.neg ? (VALUE_W'(0) - VALUE_W'(in_ch.value))
                                    : VALUE_W'(in_ch.value);
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign req.valid   = (count_reg != 2'd0);
    assign req.job     = entry_reg[rd_ptr_reg];
    assign pop         = req.valid && take;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

/* design/sbda_back.sv */
// ----------------------------------------------------------------------------
// sbda_back: conversion engine
// Splits a magnitude into decimal digits one per cycle, then sends the sign
// and the digits, most significant first, through an output register.
// ----------------------------------------------------------------------------
module sbda_back #(
    parameter int DIGIT_SLOTS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sbda_pkg::job_req_t req,
    output logic              take,
    sbda_out_if.source        out_ch
);
    import sbda_pkg::*;

    localparam int CW = $clog2(DIGIT_SLOTS + 1);
    localparam int IW = $clog2(DIGIT_SLOTS);

    phase_t              phase_reg, phase_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;
    logic [DIGIT_W-1:0]  digit_store_reg [DIGIT_SLOTS];

    logic [2*VALUE_W-1:0] product;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [DIGIT_W-1:0]   rem;
    logic                 digit_wr;
    logic                 slot_free;

    // One division by ten per cycle via the reciprocal.
    assign product  = mag_reg * RECIP_TEN;
    assign quot     = VALUE_W'(product >> RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = DIGIT_W'(mag_reg - quot_x10);

    assign slot_free = !out_valid_reg || out_ch.ready;

    // Next state and outputs.
    always_comb
    begin
        phase_next     = phase_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        take           = 1'b0;
        digit_wr       = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.valid)
                begin
                    take       = 1'b1;
                    mag_next   = req.job.mag;
                    neg_next   = req.job.neg;
                    cnt_next   = '0;
                    phase_next = PH_SPLIT;
                end
            end
            PH_SPLIT:
            begin
                digit_wr = 1'b1;
                mag_next = quot;
                cnt_next = cnt_reg + CW'(1);
                idx_next = cnt_reg[IW-1:0];
                if (quot == '0 || cnt_reg == CW'(DIGIT_SLOTS - 1))
                begin
                    phase_next = neg_reg ? PH_SIGN : PH_DIGITS;
                end
            end
            PH_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    phase_next     = PH_DIGITS;
                end
            end
            PH_DIGITS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + CHAR_W'(digit_store_reg[idx_reg]);
                    out_last_next  = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (digit_wr)
        begin
            digit_store_reg[cnt_reg[IW-1:0]] <= rem;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.char_code = out_char_reg;
    assign out_ch.last      = out_last_reg;

endmodule

/* design/signed_binary_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core: integer to decimal text
// Prints a signed 32-bit integer as ASCII characters with a last mark.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one signed 32-bit value per transaction. out_ch carries one
//   ASCII character per transaction, most significant digit first, led by
//   '-' for negative values, with last high on the final character.
//   A two-entry queue takes inputs while the engine is busy, so up to two
//   numbers can wait behind the one being printed.
// Operation:
//   The engine takes a job from the queue, then splits off its digits with
//   one reciprocal multiply per digit, then sends the sign and the digits
//   through its output register. It takes no new job before the last
//   character of the current number has entered the output register.
// Reset and stalls:
//   Reset empties the queue and the output register. While out_ch.ready is
//   low the current character holds and the engine waits before it sends
//   another; the queue keeps accepting until both entries are full.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core #(
    parameter int DIGIT_SLOTS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    sbda_in_if.sink    in_ch,
    sbda_out_if.source out_ch
);
    import sbda_pkg::*;

    job_req_t req;
    logic     take;

    sbda_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .req   (req),
        .take  (take)
    );

    sbda_back #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .take   (take),
        .out_ch (out_ch)
    );

    // Every emitted character is a minus sign or a decimal digit.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.char_code == CHAR_MINUS)
                      || (out_ch.char_code >= CHAR_ZERO
                          && out_ch.char_code <= CHAR_ZERO + 7'd9))
        else $error("illegal character code");

    // A minus sign never ends a run.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.char_code == CHAR_MINUS) |-> !out_ch.last)
        else $error("minus sign marked last");

    // The engine only takes a job from a non-empty queue.
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> req.valid)
        else $error("job taken from empty queue");

    // A character after a minus sign is a digit.
    a_digit_after_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.char_code == CHAR_MINUS)
        |=> !(out_ch.valid && out_ch.char_code == CHAR_MINUS))
        else $error("two minus signs in a row");

endmodule

/* bench/signed_binary_to_decimal_ascii_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core_tb: self-checking bench for the converter
// Feeds signed 32-bit values through the input channel and checks every ASCII
// character and last mark on the output channel against a software version
// of the decimal conversion. It runs a short directed set of boundary values,
// then random values spread over all digit counts and signs, under several
// mixes of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core_tb;
    import sbda_pkg::*;

    localparam int DIGIT_SLOTS    = 10;
    localparam int NUM_PHASES     = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 40;
    localparam int TIMEOUT_NS     = 3_000_000;

    // One expected character of a number's decimal text.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n;

    sbda_in_if  in_ch ();
    sbda_out_if out_ch ();

    signed_binary_to_decimal_ascii_core #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Values waiting to be sent and characters waiting to be seen.
    logic signed [VALUE_W-1:0] pending_values[$];
    text_char_t                expected_chars[$];

    logic        in_taken;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned failures;
    int unsigned numbers_taken;
    int unsigned negatives_taken;
    int unsigned chars_checked;
    int unsigned longest_text;

    // Idling mix of each phase, in percent of cycles.
    int unsigned phase_send_idle[NUM_PHASES]  = '{0, 87, 0, 34};
    int unsigned phase_recv_stall[NUM_PHASES] = '{0, 0, 87, 34};
    int unsigned phase_items[NUM_PHASES]      = '{52, 52, 52, 52};

    // Boundary values: zero, single digits, power-of-ten steps near both
    // ends, both extremes and alternating bit patterns.
    logic signed [VALUE_W-1:0] boundary_values[] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
        -32'sd999, 32'sd12345, 32'sd999999999, 32'sd1000000000,
        -32'sd999999999, -32'sd1000000000, 32'sh7FFF_FFFF, 32'sh8000_0000,
        32'sh8000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0,
        -32'sd9, 32'sd4294967
    };

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Record a failure; only the first few are described.
    function automatic void note_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Work out the characters that one number prints as and queue them.
    function automatic void predict_decimal_text(logic signed [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [DIGIT_W-1:0] digits[DIGIT_SLOTS];
        int                 digit_total;
        text_char_t         c;

        magnitude   = value[VALUE_W-1] ? (32'd0 - value) : value;
        digit_total = 0;
        // Peel off digits, least significant first.
        do
        begin
            digits[digit_total] = DIGIT_W'(magnitude % 10);
            digit_total++;
            magnitude = magnitude / 10;
        end while (magnitude != 0 && digit_total < DIGIT_SLOTS);

        if (value[VALUE_W-1])
        begin
            c.char_code = CHAR_MINUS;
            c.last      = 1'b0;
            expected_chars.push_back(c);
            negatives_taken++;
        end
        for (int j = digit_total - 1; j >= 0; j--)
        begin
            c.char_code = CHAR_ZERO + CHAR_W'(digits[j]);
            c.last      = (j == 0);
            expected_chars.push_back(c);
        end
        if (digit_total + value[VALUE_W-1] > longest_text)
        begin
            longest_text = digit_total + value[VALUE_W-1];
        end
    endfunction

    // Random value: mostly a random digit count and sign, some raw 32-bit
    // patterns and some boundary values.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int unsigned    kind;
        int unsigned    digit_total;
        logic           neg;
        longint unsigned low_mag;
        longint unsigned high_mag;
        longint unsigned ceiling;
        longint unsigned mag;
        logic [VALUE_W-1:0] bits;

        kind = $urandom_range(9);
        if (kind < 2)
        begin
            return $urandom;
        end
        if (kind == 2)
        begin
            return boundary_values[$urandom_range(boundary_values.size() - 1)];
        end
        neg         = $urandom_range(1);
        digit_total = $urandom_range(10, 1);
        low_mag     = 1;
        for (int k = 1; k < digit_total; k++)
        begin
            low_mag = low_mag * 10;
        end
        high_mag = low_mag * 10 - 1;
        ceiling  = neg ? 64'd2147483648 : 64'd2147483647;
        if (high_mag > ceiling)
        begin
            high_mag = ceiling;
        end
        if (digit_total == 1)
        begin
            low_mag = 0;
        end
        mag  = low_mag + ({$urandom, $urandom} % (high_mag - low_mag + 1));
        bits = mag[VALUE_W-1:0];
        return neg ? (32'd0 - bits) : bits;
    endfunction

    // Input driver: offers the next pending value once the last one is taken.
    always @(negedge clk)
    begin : driver
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.value <= pending_values.pop_front();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts accepted numbers and checks every emitted character.
    always @(posedge clk)
    begin : monitor
        text_char_t want;

        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                predict_decimal_text(in_ch.value);
                numbers_taken++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    note_failure($sformatf("unexpected character %0d last %0b",
                                           out_ch.char_code, out_ch.last));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (out_ch.char_code !== want.char_code || out_ch.last !== want.last)
                    begin
                        note_failure($sformatf("char_code exp %0d got %0d, last exp %0b got %0b",
                                               want.char_code, out_ch.char_code,
                                               want.last, out_ch.last));
                    end
                end
            end
        end
    end

    // Wait until every queued value is taken and all its text has arrived.
    // The clock edge after the queue empties lets the last popped value
    // reach the valid line before the idle condition is tested.
    task automatic drain_all();
        wait (pending_values.size() == 0);
        @(posedge clk);
        wait (!in_ch.valid && expected_chars.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus and end of run.
    initial
    begin : stimulus
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        failures       = 0;
        numbers_taken  = 0;
        negatives_taken = 0;
        chars_checked  = 0;
        longest_text   = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed boundary values with no idling on either side.
        foreach (boundary_values[i])
        begin
            pending_values.push_back(boundary_values[i]);
        end
        drain_all();

        // Random values under each idling mix; the sender pauses between
        // phases until every expected character has come out.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct  = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            for (int i = 0; i < phase_items[p]; i++)
            begin
                pending_values.push_back(random_value());
            end
            drain_all();
        end

        if (expected_chars.size() != 0)
        begin
            note_failure($sformatf("%0d characters never arrived", expected_chars.size()));
        end

        $display("Converted %0d numbers (%0d negative) into %0d checked characters,",
                 numbers_taken, negatives_taken, chars_checked);
        $display("longest text %0d characters, over four sender/receiver idling mixes.",
                 longest_text);
        if (failures == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d failures", failures);
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Timeout with %0d values pending and %0d characters outstanding.",
                 pending_values.size(), expected_chars.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
